>>> rtl/bsp_pkg.sv
// Shared types, codes and helpers of the bencode structure parser.
// Used through scoped names by every rtl file but bsp_ram; depends on nothing.
package bsp_pkg;

   localparam int VAL_W   = 63;
   localparam int COUNT_W = 21;

   localparam logic [VAL_W-1:0]   VAL_MAX         = {VAL_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] MAX_BYTES_RESET = COUNT_W'(1024 * 500);

   localparam logic [7:0] CH_DICT  = 8'h64;  // d
   localparam logic [7:0] CH_INT   = 8'h69;  // i
   localparam logic [7:0] CH_LIST  = 8'h6C;  // l
   localparam logic [7:0] CH_END   = 8'h65;  // e
   localparam logic [7:0] CH_COLON = 8'h3A;  // :
   localparam logic [7:0] CH_ZERO  = 8'h30;  // 0
   localparam logic [7:0] CH_NINE  = 8'h39;  // 9
   localparam logic [3:0] RADIX    = 4'd10;

   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_COMPLETE  = 4'd1,
      ST_BAD_TYPE  = 4'd2,
      ST_NO_COLON  = 4'd3,
      ST_INT_DIGIT = 4'd4,
      ST_INT_END   = 4'd5,
      ST_KEY_STR   = 4'd6,
      ST_TOO_DEEP  = 4'd7,
      ST_EMPTY     = 4'd8,
      ST_TRUNC     = 4'd9,
      ST_TOO_LARGE = 4'd10
   } status_type;

   typedef enum logic [2:0] {
      TK_NONE      = 3'd0,
      TK_DICT      = 3'd1,
      TK_LIST      = 3'd2,
      TK_END       = 3'd3,
      TK_INT       = 3'd4,
      TK_LENGTH    = 3'd5,
      TK_PAYLOAD   = 3'd6,
      TK_STR_DONE  = 3'd7
   } token_type;

   typedef enum logic [1:0] {
      FR_LIST = 2'd0,
      FR_DKEY = 2'd1,
      FR_DVAL = 2'd2
   } frame_type;

   // Request from the parser to the frame stack for one accepted word.
   typedef struct packed {
      logic      clear;
      logic      push;
      logic      pop;
      logic      advance;
      frame_type frame;
   } stack_op_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic [3:0] digit_value(input logic [7:0] c);
      logic [7:0] diff;
      diff = c - CH_ZERO;
      return diff[3:0];
   endfunction

   // acc * 10 + digit, held at VAL_MAX when it overflows.
   function automatic logic [VAL_W-1:0] accumulate(input logic [VAL_W-1:0] acc,
                                                   input logic [3:0]       digit);
      logic [VAL_W+3:0] wide;
      wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{VAL_W{1'b0}}, digit};
      if (wide > {4'b0, VAL_MAX}) begin
         return VAL_MAX;
      end
      return wide[VAL_W-1:0];
   endfunction

   // A finished value flips a dictionary frame between key and value.
   function automatic frame_type frame_toggle(input frame_type f);
      frame_type r;
      case (f)
         FR_DKEY: r = FR_DVAL;
         FR_DVAL: r = FR_DKEY;
         default: r = f;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/bsp_if.sv
// Channel interfaces of the bencode structure parser: byte input, result
// output and the configuration write channel. Depends on bsp_pkg.
interface bsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;
   logic       last_byte;

   modport source (output valid, data_byte, first_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface bsp_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [3:0]                status;
   logic [2:0]                token_kind;
   logic [bsp_pkg::VAL_W-1:0] token_value;
   logic [7:0]                payload_byte;
   logic                      string_is_key;
   logic [5:0]                nesting_depth;
   logic                      last_result;

   modport source (output valid, status, token_kind, token_value, payload_byte,
                   string_is_key, nesting_depth, last_result, input ready);
   modport sink   (input valid, status, token_kind, token_value, payload_byte,
                   string_is_key, nesting_depth, last_result, output ready);
endinterface

interface bsp_csr_if;
   logic                        valid;
   logic                        ready;
   logic [bsp_pkg::COUNT_W-1:0] max_input_bytes;

   modport source (output valid, max_input_bytes, input ready);
   modport sink   (input valid, max_input_bytes, output ready);
endinterface

>>> rtl/bsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> rtl/bsp_frame_stack.sv
// Container frame stack: top frame in a register, lower frames in bsp_ram.
// Depends on bsp_pkg and bsp_ram.
module bsp_frame_stack #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bsp_pkg::stack_op_type            op,
   output logic [$clog2(STACK_DEPTH+1)-1:0] depth,
   output bsp_pkg::frame_type               top_frame
);

   localparam int SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   logic [SP_W-1:0]    sp_ff, sp_in, sp_eff, sp_m1, sp_m2;
   bsp_pkg::frame_type tos_ff, tos_in, base, below;
   logic               fwd_ff, fwd_in;
   logic [1:0]         fwd_data_ff;
   logic [1:0]         ram_rdata;
   logic               we;
   logic [ADDR_W-1:0]  waddr, raddr;

   // The RAM is always reading the frame just below the next top, so that a
   // pop finds it waiting. A push writes that very entry, hence the bypass.
   always_comb begin
      sp_eff = op.clear ? '0 : sp_ff;
      below  = fwd_ff ? bsp_pkg::frame_type'(fwd_data_ff)
                      : bsp_pkg::frame_type'(ram_rdata);
      base   = op.pop ? below : tos_ff;
      if (op.push) begin
         tos_in = op.frame;
      end else if (op.advance) begin
         tos_in = bsp_pkg::frame_toggle(base);
      end else begin
         tos_in = base;
      end
      if (op.push) begin
         sp_in = sp_eff + 1'b1;
      end else if (op.pop) begin
         sp_in = sp_eff - 1'b1;
      end else begin
         sp_in = sp_eff;
      end
      sp_m1  = sp_eff - 1'b1;
      sp_m2  = sp_in - SP_W'(2);
      we     = op.push && (sp_eff != '0);
      waddr  = sp_m1[ADDR_W-1:0];
      raddr  = sp_m2[ADDR_W-1:0];
      fwd_in = we && (waddr == raddr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff  <= '0;
         fwd_ff <= 1'b0;
      end else begin
         sp_ff  <= sp_in;
         fwd_ff <= fwd_in;
      end
      tos_ff      <= tos_in;
      fwd_data_ff <= tos_ff;
   end

   bsp_ram #(
      .WIDTH (2),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (tos_ff),
      .raddr (raddr),
      .rdata (ram_rdata)
   );

   assign depth     = sp_ff;
   assign top_frame = tos_ff;

endmodule

>>> rtl/bencode_structure_parser.sv
// Bencode structure parser: byte-serial checker of bencoded documents.
// Depends on bsp_pkg, the bsp interfaces and bsp_frame_stack.
//
// Usage:
//   req_chan carries one document byte per word with first_byte (clears the
//   parser before the byte is taken) and last_byte marks. Every accepted
//   byte produces exactly one word on rsp_chan: status, token event, integer
//   value or string length, payload byte, key flag, nesting depth and a copy
//   of last_byte.
//   csr_chan writes max_input_bytes; it is always ready and should only be
//   written while no byte is in flight.
// Timing:
//   A result appears in the cycle after its byte is accepted. One byte is
//   taken every cycle unless rsp_chan stalls; the per-byte rate is set by
//   the read-modify-write of the frame stack, whose top frame is held in a
//   register and whose lower frames sit in a RAM read ahead of each pop.
//   req_chan.ready falls only while the result register is full and
//   rsp_chan.ready is low; a stalled receiver holds the parser in place.
// Reset:
//   Synchronous, active high. Clears the parser, empties the stack and sets
//   max_input_bytes to 512000. No clearing pass is needed.
module bencode_structure_parser #(
   parameter int STACK_DEPTH = 32
) (
   input logic          clock,
   input logic          reset,
   bsp_req_if.sink      req_chan,
   bsp_rsp_if.source    rsp_chan,
   bsp_csr_if.sink      csr_chan
);

   localparam int SP_W  = $clog2(STACK_DEPTH + 1);
   localparam int VAL_W = bsp_pkg::VAL_W;
   localparam int CNT_W = bsp_pkg::COUNT_W;

   typedef enum logic [2:0] {
      MODE_WAIT,
      MODE_STR_LEN,
      MODE_STR_BODY,
      MODE_INT_FIRST,
      MODE_INT_DIGITS,
      MODE_DONE
   } mode_type;

   mode_type           mode_ff, mode_in, mode_eff;
   logic [VAL_W-1:0]   acc_ff, acc_in, acc_eff;
   logic [VAL_W-1:0]   rem_ff, rem_in, rem_eff, rem_dec;
   logic [CNT_W-1:0]   count_ff, count_in, count_eff;
   logic [CNT_W-1:0]   max_bytes_ff;
   bsp_pkg::status_type err_ff, err_in, err_eff;

   logic               rsp_valid_ff;
   logic [3:0]         status_ff;
   logic [2:0]         kind_ff;
   logic [VAL_W-1:0]   value_ff;
   logic [7:0]         pay_ff;
   logic               key_ff;
   logic [5:0]         depth_ff;
   logic               last_ff;

   logic               fire;
   logic [7:0]         c;
   logic               first, last;
   bsp_pkg::stack_op_type op;
   logic [SP_W-1:0]    sp, sp_eff, sp_after;
   logic [SP_W+5:0]    depth_wide;
   bsp_pkg::frame_type tos;
   logic               top_key, value_done;
   bsp_pkg::token_type kind;
   logic [VAL_W-1:0]   val;
   logic [7:0]         pay;
   logic               key;
   bsp_pkg::status_type status;

   assign fire = req_chan.valid && req_chan.ready;
   assign c     = req_chan.data_byte;
   assign first = req_chan.first_byte;
   assign last  = req_chan.last_byte;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      sp_eff    = first ? '0 : sp;
      mode_eff  = first ? MODE_WAIT : mode_ff;
      acc_eff   = first ? '0 : acc_ff;
      rem_eff   = first ? '0 : rem_ff;
      count_eff = first ? '0 : count_ff;
      err_eff   = first ? bsp_pkg::ST_OK : err_ff;

      mode_in    = mode_eff;
      acc_in     = acc_eff;
      rem_in     = rem_eff;
      count_in   = count_eff;
      err_in     = err_eff;
      op         = '0;
      op.clear   = first;
      op.frame   = bsp_pkg::FR_LIST;
      value_done = 1'b0;
      kind       = bsp_pkg::TK_NONE;
      val        = '0;
      pay        = '0;
      key        = 1'b0;
      top_key    = (sp_eff != '0) && (tos == bsp_pkg::FR_DKEY);
      rem_dec    = (rem_eff != '0) ? rem_eff - 1'b1 : rem_eff;

      if (err_eff == bsp_pkg::ST_OK) begin
         if (count_eff != bsp_pkg::COUNT_MAX) begin
            count_in = count_eff + 1'b1;
         end
         if (count_in > max_bytes_ff) begin
            err_in = bsp_pkg::ST_TOO_LARGE;
         end
      end

      if (err_in == bsp_pkg::ST_OK) begin
         case (mode_eff)
            MODE_WAIT: begin
               if (c == bsp_pkg::CH_END) begin
                  if (sp_eff == '0) begin
                     err_in = bsp_pkg::ST_EMPTY;
                  end else if (tos == bsp_pkg::FR_DVAL) begin
                     err_in = bsp_pkg::ST_BAD_TYPE;
                  end else begin
                     op.pop     = 1'b1;
                     kind       = bsp_pkg::TK_END;
                     value_done = 1'b1;
                  end
               end else if (top_key && !bsp_pkg::is_digit(c)) begin
                  err_in = bsp_pkg::ST_KEY_STR;
               end else if (c == bsp_pkg::CH_DICT || c == bsp_pkg::CH_LIST) begin
                  if (sp_eff >= SP_W'(STACK_DEPTH)) begin
                     err_in = bsp_pkg::ST_TOO_DEEP;
                  end else begin
                     op.push = 1'b1;
                     if (c == bsp_pkg::CH_DICT) begin
                        op.frame = bsp_pkg::FR_DKEY;
                        kind     = bsp_pkg::TK_DICT;
                     end else begin
                        kind     = bsp_pkg::TK_LIST;
                     end
                  end
               end else if (c == bsp_pkg::CH_INT) begin
                  mode_in = MODE_INT_FIRST;
               end else if (bsp_pkg::is_digit(c)) begin
                  acc_in  = {{(VAL_W-4){1'b0}}, bsp_pkg::digit_value(c)};
                  mode_in = MODE_STR_LEN;
                  key     = top_key;
               end else begin
                  err_in = bsp_pkg::ST_BAD_TYPE;
               end
            end
            MODE_INT_FIRST: begin
               if (bsp_pkg::is_digit(c)) begin
                  acc_in  = {{(VAL_W-4){1'b0}}, bsp_pkg::digit_value(c)};
                  mode_in = MODE_INT_DIGITS;
               end else begin
                  err_in = bsp_pkg::ST_INT_DIGIT;
               end
            end
            MODE_INT_DIGITS: begin
               if (bsp_pkg::is_digit(c)) begin
                  acc_in = bsp_pkg::accumulate(acc_eff, bsp_pkg::digit_value(c));
               end else if (c == bsp_pkg::CH_END) begin
                  kind       = bsp_pkg::TK_INT;
                  val        = acc_eff;
                  value_done = 1'b1;
               end else begin
                  err_in = bsp_pkg::ST_INT_END;
               end
            end
            MODE_STR_LEN: begin
               key = top_key;
               if (bsp_pkg::is_digit(c)) begin
                  acc_in = bsp_pkg::accumulate(acc_eff, bsp_pkg::digit_value(c));
               end else if (c == bsp_pkg::CH_COLON) begin
                  kind   = bsp_pkg::TK_LENGTH;
                  val    = acc_eff;
                  rem_in = acc_eff;
                  if (acc_eff == '0) begin
                     value_done = 1'b1;
                  end else begin
                     mode_in = MODE_STR_BODY;
                  end
               end else begin
                  err_in = bsp_pkg::ST_NO_COLON;
               end
            end
            MODE_STR_BODY: begin
               key    = top_key;
               pay    = c;
               rem_in = rem_dec;
               if (rem_dec == '0) begin
                  kind       = bsp_pkg::TK_STR_DONE;
                  value_done = 1'b1;
               end else begin
                  kind = bsp_pkg::TK_PAYLOAD;
               end
            end
            default: begin
            end
         endcase

         if (op.push) begin
            sp_after = sp_eff + 1'b1;
         end else if (op.pop) begin
            sp_after = sp_eff - 1'b1;
         end else begin
            sp_after = sp_eff;
         end
         if (value_done) begin
            if (sp_after == '0) begin
               mode_in = MODE_DONE;
            end else begin
               mode_in    = MODE_WAIT;
               op.advance = 1'b1;
            end
         end
         if (err_in == bsp_pkg::ST_OK && last && mode_in != MODE_DONE) begin
            err_in = bsp_pkg::ST_TRUNC;
         end
      end else begin
         sp_after = sp_eff;
      end

      if (err_in != bsp_pkg::ST_OK) begin
         kind   = bsp_pkg::TK_NONE;
         val    = '0;
         pay    = '0;
         key    = 1'b0;
         status = err_in;
      end else if (mode_in == MODE_DONE) begin
         status = bsp_pkg::ST_COMPLETE;
      end else begin
         status = bsp_pkg::ST_OK;
      end
      depth_wide = {6'b0, sp_after};

      // Nothing moves unless the byte is actually taken.
      if (!fire) begin
         mode_in  = mode_ff;
         acc_in   = acc_ff;
         rem_in   = rem_ff;
         count_in = count_ff;
         err_in   = err_ff;
         op       = '0;
      end
   end

   bsp_frame_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .depth     (sp),
      .top_frame (tos)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_WAIT;
         acc_ff       <= '0;
         rem_ff       <= '0;
         count_ff     <= '0;
         err_ff       <= bsp_pkg::ST_OK;
         max_bytes_ff <= bsp_pkg::MAX_BYTES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         acc_ff   <= acc_in;
         rem_ff   <= rem_in;
         count_ff <= count_in;
         err_ff   <= err_in;
         if (csr_chan.valid) begin
            max_bytes_ff <= csr_chan.max_input_bytes;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (fire) begin
         status_ff <= status;
         kind_ff   <= kind;
         value_ff  <= val;
         pay_ff    <= pay;
         key_ff    <= key;
         depth_ff  <= depth_wide[5:0];
         last_ff   <= last;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.token_kind    = kind_ff;
   assign rsp_chan.token_value   = value_ff;
   assign rsp_chan.payload_byte  = pay_ff;
   assign rsp_chan.string_is_key = key_ff;
   assign rsp_chan.nesting_depth = depth_ff;
   assign rsp_chan.last_result   = last_ff;

`ifndef ASSERT_OFF
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      sp <= SP_W'(STACK_DEPTH))
      else $error("frame stack depth beyond its capacity");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_chan.valid)
      else $error("accepted byte produced no result word");

   a_sticky_error: assert property (@(posedge clock) disable iff (reset)
      (fire && !first && err_ff != bsp_pkg::ST_OK) |=> (err_ff == $past(err_ff)))
      else $error("error code changed without a first byte");

   a_error_silent: assert property (@(posedge clock) disable iff (reset)
      (fire && err_in != bsp_pkg::ST_OK) |=> (kind_ff == bsp_pkg::TK_NONE))
      else $error("token reported on an errored byte");
`endif

endmodule
